// ===== src/lcar_pkg.sv =====
// ----------------------------------------------------------------------------
// Load cell reader package
// Widths, constants and transfer types shared by the reader and its checker.
// ----------------------------------------------------------------------------
package lcar_pkg;

  localparam int CODE_BITS    = 24;
  localparam int DIVISOR_BITS = 16;

  typedef struct packed {
    logic data_level;
    logic mode;
  } tick_t;

  typedef struct packed {
    logic                 clock_level;
    logic                 conversion_done;
    logic [CODE_BITS-1:0] raw_code;
    logic [CODE_BITS-1:0] weight;
    logic                 weight_updated;
  } result_t;

endpackage

// ===== src/load_cell_adc_reader_with_tare_unit.sv =====
// ----------------------------------------------------------------------------
// Load cell reader with tare
// Drives the two-wire serial interface of a 24-bit bridge converter one
// half-bit tick at a time, shifts the code in bit by bit, captures a tare and
// scales the tare-corrected code with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  in_data  (lcar_pkg::tick_t, one tick)
//   out      out_valid/ out_stall out_data (lcar_pkg::result_t, one per tick)
//   cfg      cfg_valid/ cfg_ready cfg_data (scale divisor)
//
// A tick normally yields its result in the cycle after its transfer.
// A measure-mode completion with a code above the tare runs the divider,
// one quotient bit per cycle, and its result appears once the last quotient
// bit is in; no tick is taken meanwhile.
// Reset is synchronous and clears all state; the divisor returns to one.
// While a result waits under out_stall, in_stall is held high.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_with_tare_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lcar_pkg::tick_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lcar_pkg::result_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lcar_pkg::DIVISOR_BITS-1:0]    cfg_data
);

  localparam int CB    = lcar_pkg::CODE_BITS;
  localparam int DB    = lcar_pkg::DIVISOR_BITS;
  localparam int CNT_W = $clog2(CB + 1);
  localparam logic [CB-1:0]    SIGN     = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(CB - 1);

  typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW, PH_TAIL} phase_t;
  typedef enum logic {CTL_RUN, CTL_DIV} ctl_t;

  phase_t          phase;
  ctl_t            ctl;
  logic [CNT_W-1:0] bit_count;
  logic [CNT_W-1:0] div_count;
  logic [CB-1:0]   shift_value;
  logic            latched_mode;
  logic [CB-1:0]   tare_value;
  logic [CB-1:0]   weight_value;
  logic [CB-1:0]   last_code;
  logic [DB-1:0]   scale_divisor;
  logic [DB-1:0]   divisor;
  logic [DB-1:0]   rem;
  logic [CB-1:0]   quo;

  logic            accept;
  logic [CB-1:0]   sample_code;
  logic [CB-1:0]   diff;
  logic [DB:0]     shifted;
  logic [DB+1:0]   trial;
  logic            take;
  logic [DB-1:0]   rem_next;
  logic [CB-1:0]   quo_next;
  logic            clock_next;
  logic            done_next;
  logic            start_div;
  logic            finish;
  logic            out_valid_next;

  assign in_stall  = (ctl == CTL_DIV) | (out_valid & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign sample_code = {shift_value[CB-2:0], in_data.data_level} ^ SIGN;
  assign diff        = sample_code - tare_value;

  assign shifted  = {rem, quo[CB-1]};
  assign trial    = {1'b0, shifted} - {2'b00, divisor};
  assign take     = ~trial[DB+1];
  assign rem_next = take ? trial[DB-1:0] : shifted[DB-1:0];
  assign quo_next = {quo[CB-2:0], take};

  always_comb begin
    clock_next = 1'b0;
    done_next  = 1'b0;
    start_div  = 1'b0;
    case (phase)
      PH_IDLE: begin
        clock_next = ~in_data.data_level;
      end
      PH_HIGH: begin
        clock_next = 1'b0;
      end
      PH_LOW: begin
        clock_next = 1'b1;
        if (bit_count == LAST_BIT) begin
          done_next = 1'b1;
          start_div = ~latched_mode & (sample_code > tare_value);
        end
      end
      default: begin
        clock_next = 1'b0;
      end
    endcase
  end

  assign finish         = (ctl == CTL_DIV) && (div_count == LAST_BIT);
  assign out_valid_next = finish | (accept & ~start_div) | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      ctl           <= CTL_RUN;
      bit_count     <= '0;
      div_count     <= '0;
      shift_value   <= '0;
      latched_mode  <= 1'b0;
      tare_value    <= '0;
      weight_value  <= '0;
      last_code     <= '0;
      scale_divisor <= DB'(1);
      divisor       <= DB'(1);
      rem           <= '0;
      quo           <= '0;
      out_valid     <= 1'b0;
      out_data      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale_divisor <= cfg_data;
      end
      out_valid <= out_valid_next;

      if (ctl == CTL_DIV) begin
        rem       <= rem_next;
        quo       <= quo_next;
        div_count <= div_count + CNT_W'(1);
        if (div_count == LAST_BIT) begin
          ctl          <= CTL_RUN;
          weight_value <= quo_next;
          out_data     <= {1'b1, 1'b1, last_code, quo_next, 1'b1};
        end
      end else if (accept) begin
        out_data <= {clock_next, done_next, done_next ? sample_code : last_code,
                     weight_value, 1'b0};
        case (phase)
          PH_IDLE: begin
            if (!in_data.data_level) begin
              latched_mode <= in_data.mode;
              bit_count    <= '0;
              shift_value  <= '0;
              phase        <= PH_HIGH;
            end
          end
          PH_HIGH: begin
            phase <= PH_LOW;
          end
          PH_LOW: begin
            shift_value <= {shift_value[CB-2:0], in_data.data_level};
            bit_count   <= bit_count + CNT_W'(1);
            if (bit_count == LAST_BIT) begin
              phase     <= PH_TAIL;
              last_code <= sample_code;
              if (latched_mode) begin
                tare_value <= sample_code;
              end
            end else begin
              phase <= PH_HIGH;
            end
          end
          default: begin
            phase <= PH_IDLE;
          end
        endcase
        if (start_div) begin
          ctl       <= CTL_DIV;
          div_count <= '0;
          rem       <= '0;
          quo       <= diff;
          divisor   <= (scale_divisor == '0) ? DB'(1) : scale_divisor;
        end
      end
    end
  end

endmodule

// ===== src/lcar_checker.sv =====
// ----------------------------------------------------------------------------
// Load cell reader port checker
// Watches the reader's ports over time and flags results or stalls that the
// interface never shows on a correct design.
// ----------------------------------------------------------------------------
module lcar_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input lcar_pkg::result_t                 out_data
);

  // A result waiting under stall stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No new tick is taken while the previous result is still waiting.
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input open while result is stalled");

  // A weight update only ever comes with a completed conversion.
  a_upd_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.weight_updated |-> out_data.conversion_done)
    else $error("weight update without conversion");

  // The completing tick always starts the trailing clock pulse.
  a_done_clock: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.conversion_done |-> out_data.clock_level)
    else $error("conversion done with clock low");

endmodule

bind load_cell_adc_reader_with_tare_unit lcar_checker u_lcar_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Load cell reader with tare: self-checking bench
// The bench drives converter ticks through the valid/stall tick channel. Most
// ticks form whole serial conversions with chosen codes, in tare and measure
// mode. The scale divisor is rewritten between phases while the block is
// idle. A predictor works out the reading that each tick should give, and
// every reading transfer is compared field by field. Both channels idle and
// stall at random, except for one calm stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODE_BITS    = lcar_pkg::CODE_BITS;
  localparam int DIVISOR_BITS = lcar_pkg::DIVISOR_BITS;
  localparam int unsigned CYCLE_LIMIT = 20000;
  localparam int unsigned ITEM_COUNT  = 400;
  localparam logic [CODE_BITS-1:0] SIGN_BIT = {1'b1, {(CODE_BITS-1){1'b0}}};
  localparam logic [CODE_BITS-1:0] FULL_CODE = '1;

  typedef enum logic [1:0] {WAIT_LOW, CLK_HIGH, CLK_LOW, TRAIL} link_phase_t;

  class reading_checker_t;
    link_phase_t              phase;
    logic [4:0]               bits_in;
    logic [CODE_BITS-1:0]     shifter;
    logic                     held_mode;
    logic [CODE_BITS-1:0]     tare;
    logic [CODE_BITS-1:0]     weight;
    logic [CODE_BITS-1:0]     last_code;
    logic [DIVISOR_BITS-1:0]  divisor;
    lcar_pkg::result_t        due_readings[$];
    int unsigned              ticks;
    int unsigned              failures;

    function new();
      phase = WAIT_LOW;
      bits_in = '0;
      shifter = '0;
      held_mode = 1'b0;
      tare = '0;
      weight = '0;
      last_code = '0;
      divisor = DIVISOR_BITS'(1);
      ticks = 0;
      failures = 0;
    endfunction

    function void note_tick(lcar_pkg::tick_t t);
      lcar_pkg::result_t    r;
      logic [CODE_BITS-1:0] code;
      logic [CODE_BITS-1:0] div;
      r = '0;
      case (phase)
        WAIT_LOW: begin
          if (!t.data_level) begin
            held_mode = t.mode;
            bits_in = '0;
            shifter = '0;
            r.clock_level = 1'b1;
            phase = CLK_HIGH;
          end
        end
        CLK_HIGH: phase = CLK_LOW;
        CLK_LOW: begin
          shifter = {shifter[CODE_BITS-2:0], t.data_level};
          bits_in = bits_in + 5'd1;
          r.clock_level = 1'b1;
          if (bits_in >= CODE_BITS) begin
            code = shifter ^ SIGN_BIT;
            r.conversion_done = 1'b1;
            last_code = code;
            if (held_mode) begin
              tare = code;
            end else if (code > tare) begin
              div = (divisor == '0) ? CODE_BITS'(1) : CODE_BITS'(divisor);
              weight = (code - tare) / div;
              r.weight_updated = 1'b1;
            end
            phase = TRAIL;
          end else begin
            phase = CLK_HIGH;
          end
        end
        default: phase = WAIT_LOW;
      endcase
      r.raw_code = last_code;
      r.weight = weight;
      due_readings.push_back(r);
      ticks++;
    endfunction

    function void check_reading(lcar_pkg::result_t got);
      lcar_pkg::result_t want;
      if (due_readings.size() == 0) begin
        $error("reading transfer with none expected: %h", got);
        failures++;
        return;
      end
      want = due_readings.pop_front();
      if (got.clock_level !== want.clock_level) begin
        $error("clock_level: expected %0d, got %0d",
               want.clock_level, got.clock_level);
        failures++;
      end
      if (got.conversion_done !== want.conversion_done) begin
        $error("conversion_done: expected %0d, got %0d",
               want.conversion_done, got.conversion_done);
        failures++;
      end
      if (got.raw_code !== want.raw_code) begin
        $error("raw_code: expected %h, got %h", want.raw_code, got.raw_code);
        failures++;
      end
      if (got.weight !== want.weight) begin
        $error("weight: expected %h, got %h", want.weight, got.weight);
        failures++;
      end
      if (got.weight_updated !== want.weight_updated) begin
        $error("weight_updated: expected %0d, got %0d",
               want.weight_updated, got.weight_updated);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return due_readings.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  lcar_pkg::tick_t         in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  lcar_pkg::result_t       out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [DIVISOR_BITS-1:0] cfg_data = '0;

  reading_checker_t book = new();
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;

  load_cell_adc_reader_with_tare_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      book.check_reading(out_data);
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 17);
  end

  function automatic lcar_pkg::tick_t rand_tick();
    lcar_pkg::tick_t t;
    t = lcar_pkg::tick_t'(2'($urandom_range(0, 3)));
    return t;
  endfunction

  task automatic send_tick(input lcar_pkg::tick_t t);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_tick(t);
  endtask

  // Any conversion left open by noise is first finished with random bits.
  task automatic run_conversion(input logic tare_mode, input logic [CODE_BITS-1:0] code,
                                input int unsigned gap);
    logic [CODE_BITS-1:0] line_bits;
    lcar_pkg::tick_t      t;
    line_bits = code ^ SIGN_BIT;
    while (book.phase != WAIT_LOW) send_tick(rand_tick());
    repeat (gap) begin
      t.data_level = 1'b1;
      t.mode = 1'($urandom_range(0, 1));
      send_tick(t);
    end
    t.data_level = 1'b0;
    t.mode = tare_mode;
    send_tick(t);
    while (book.phase != TRAIL) begin
      t.mode = 1'($urandom_range(0, 1));
      if (book.phase == CLK_LOW) begin
        t.data_level = line_bits[CODE_BITS - 1 - book.bits_in];
      end else begin
        t.data_level = 1'($urandom_range(0, 1));
      end
      send_tick(t);
    end
    send_tick(rand_tick());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (CODE_BITS + 8) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [DIVISOR_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    book.divisor = value;
  endtask

  function automatic logic [CODE_BITS-1:0] pick_code();
    logic [CODE_BITS-1:0] code;
    case ($urandom_range(0, 7))
      0: code = '0;
      1: code = FULL_CODE;
      2: code = book.tare + CODE_BITS'($urandom_range(0, 3));
      3: code = book.tare - CODE_BITS'($urandom_range(0, 3));
      default: code = CODE_BITS'($urandom_range(0, 32'hFFFFFF));
    endcase
    return code;
  endfunction

  function automatic logic [DIVISOR_BITS-1:0] pick_divisor();
    logic [DIVISOR_BITS-1:0] value;
    case ($urandom_range(0, 4))
      0: value = DIVISOR_BITS'($urandom_range(1, 15));
      1: value = '0;
      2: value = '1;
      default: value = DIVISOR_BITS'($urandom_range(1, 16'hFFFF));
    endcase
    return value;
  endfunction

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("load_cell_adc_reader_with_tare_unit: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The divisor is still at its reset value of one here.
    run_conversion(1'b0, '0, 1);
    run_conversion(1'b1, FULL_CODE, 2);
    run_conversion(1'b0, FULL_CODE, 0);
    run_conversion(1'b1, 24'h123456, 0);
    run_conversion(1'b0, SIGN_BIT, 3);
    repeat (6) send_tick(rand_tick());
    settle();

    calm = 1'b1;
    write_divisor('1);
    run_conversion(1'b0, FULL_CODE, 0);
    settle();
    write_divisor('0);
    run_conversion(1'b0, FULL_CODE, 0);
    settle();
    calm = 1'b0;

    while (book.ticks < ITEM_COUNT) begin
      write_divisor(pick_divisor());
      repeat (3) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 12)) send_tick(rand_tick());
        end else begin
          run_conversion($urandom_range(0, 3) == 0, pick_code(), $urandom_range(0, 4));
        end
      end
      settle();
    end

    if (book.failures == 0 && book.pending() == 0) begin
      $display("load_cell_adc_reader_with_tare_unit: match");
    end else begin
      $display("load_cell_adc_reader_with_tare_unit: mismatch");
    end
    $finish;
  end

endmodule
